// File: design/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN_CODE16 = 7'h7e;
  localparam logic [6:0] LEN_CODE64 = 7'h7f;

  // Header byte counts at which the extended length field is complete.
  localparam logic [3:0] HDR_END16 = 4'd4;
  localparam logic [3:0] HDR_END64 = 4'd10;

  // Result kinds.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_LEN16   = 6'b000100,
    PH_LEN64   = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  // One result beat as it leaves the parser.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        mask;
    logic [63:0] body_length;
    logic [3:0]  header_size;
    logic        last;
  } result_t;

endpackage

// File: design/websocket_frame_deframer.sv
// WebSocket frame deframer: receive-side header parser and payload unmasker.
//
// The rx channel takes one byte of the frame stream per beat (rx_valid,
// rx_stall, rx_byte). The result channel gives at most one beat per input
// byte: a header beat (result_kind 0) once the base header, any extended
// length and any masking key are in, then one beat per payload byte
// (result_kind 1), unmasked with the key, the final one marked by
// last_of_frame. A frame of zero length is marked last on its header beat.
// Header bytes before completion produce no beat.
//
// A byte lands in an input register, is decoded from there and its result
// is loaded into the output register at the edge that steps the parser,
// once the output register is free. One byte is taken every cycle
// while the output is not held.
// When result_stall holds a pending beat and a byte waits in the input
// register, rx_stall rises in the same cycle; otherwise bytes keep flowing,
// including while a finished beat waits to be taken.
// Reset (rst, synchronous) empties both registers and returns the parser
// to wait for the first header byte of a frame.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic        fin_flag,
  output logic [2:0]  reserved_bits,
  output logic [3:0]  frame_opcode,
  output logic        mask_present,
  output logic [63:0] body_length,
  output logic [3:0]  header_size,
  output logic        last_of_frame
);
  import wsfd_pkg::*;

  logic    in_full;
  logic [7:0] in_byte;
  logic    out_free;
  logic    step;
  logic    take;
  logic    parse_valid;
  result_t parse_res;
  result_t out_res;

  assign out_free = !result_valid || !result_stall;
  assign step     = in_full && out_free;
  assign rx_stall = in_full && !out_free;
  assign take     = rx_valid && !rx_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= rx_byte;
    end
  end

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .res_valid (parse_valid),
    .res       (parse_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= parse_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && parse_valid) begin
      out_res <= parse_res;
    end
  end

  assign result_kind    = out_res.kind;
  assign payload_byte   = out_res.payload_byte;
  assign fin_flag       = out_res.fin;
  assign reserved_bits  = out_res.rsv;
  assign frame_opcode   = out_res.opcode;
  assign mask_present   = out_res.mask;
  assign body_length    = out_res.body_length;
  assign header_size    = out_res.header_size;
  assign last_of_frame  = out_res.last;

endmodule

// File: design/wsfd_parser.sv
// Frame parser state and the per-byte decode and unmasking logic.
module wsfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic        fin, fin_next;
  logic [2:0]  rsv, rsv_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask, mask_next;
  logic [63:0] length, length_next;
  logic [31:0] key, key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  key_idx, key_idx_next;

  logic        emit;
  logic        emit_kind;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [7:0]  key_byte;
  logic [3:0]  hdr_count_inc;
  logic [1:0]  key_idx_inc;
  logic [63:0] length_shift;

  assign hdr_count_inc = hdr_count + 4'd1;
  assign key_idx_inc   = key_idx + 2'd1;
  assign length_shift  = {length[55:0], rx_byte};

  // Key byte for the current payload position, first key byte first.
  always_comb begin
    case (key_idx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  // Next state and result for the byte at hand.
  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    fin_next       = fin;
    rsv_next       = rsv;
    opcode_next    = opcode;
    mask_next      = mask;
    length_next    = length;
    key_next       = key;
    remaining_next = remaining;
    key_idx_next   = key_idx;
    emit           = 1'b0;
    emit_kind      = KIND_HEADER;
    emit_byte      = 8'd0;
    emit_last      = 1'b0;

    case (phase)
      PH_HDR1: begin
        mask_next      = rx_byte[7];
        hdr_count_next = 4'd2;
        if (rx_byte[6:0] == LEN_CODE16) begin
          length_next = 64'd0;
          phase_next  = PH_LEN16;
        end else if (rx_byte[6:0] == LEN_CODE64) begin
          length_next = 64'd0;
          phase_next  = PH_LEN64;
        end else begin
          length_next = {57'd0, rx_byte[6:0]};
          if (rx_byte[7]) begin
            key_next     = 32'd0;
            key_idx_next = 2'd0;
            phase_next   = PH_KEY;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_LEN16, PH_LEN64: begin
        length_next    = length_shift;
        hdr_count_next = hdr_count_inc;
        if ((phase == PH_LEN16 && hdr_count_inc == HDR_END16) ||
            (phase == PH_LEN64 && hdr_count_inc == HDR_END64)) begin
          if (mask) begin
            key_next     = 32'd0;
            key_idx_next = 2'd0;
            phase_next   = PH_KEY;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_next       = {key[23:0], rx_byte};
        hdr_count_next = hdr_count_inc;
        key_idx_next   = key_idx_inc;
        if (key_idx_inc == 2'd0) begin
          emit = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        emit           = 1'b1;
        emit_kind      = KIND_PAYLOAD;
        emit_byte      = mask ? (rx_byte ^ key_byte) : rx_byte;
        emit_last      = (remaining == 64'd1);
        key_idx_next   = key_idx_inc;
        remaining_next = remaining - 64'd1;
        if (remaining == 64'd1) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        fin_next       = rx_byte[7];
        rsv_next       = rx_byte[6:4];
        opcode_next    = rx_byte[3:0];
        hdr_count_next = 4'd1;
        phase_next     = PH_HDR1;
      end
    endcase

    // Header completion: load the payload counter and pick the next phase.
    if (emit && emit_kind == KIND_HEADER) begin
      emit_last      = (length_next == 64'd0);
      remaining_next = length_next;
      key_idx_next   = 2'd0;
      phase_next     = (length_next == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
    end
  end

  // The result carries the header fields as they stand after this byte.
  always_comb begin
    res_valid          = step && emit;
    res.kind           = emit_kind;
    res.payload_byte   = emit_byte;
    res.fin            = fin_next;
    res.rsv            = rsv_next;
    res.opcode         = opcode_next;
    res.mask           = mask_next;
    res.body_length    = length_next;
    res.header_size    = hdr_count_next;
    res.last           = emit_last;
  end

  // Parser state advances once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      hdr_count <= 4'd0;
      fin       <= 1'b0;
      rsv       <= 3'd0;
      opcode    <= 4'd0;
      mask      <= 1'b0;
      length    <= 64'd0;
      key       <= 32'd0;
      remaining <= 64'd0;
      key_idx   <= 2'd0;
    end else if (step) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      fin       <= fin_next;
      rsv       <= rsv_next;
      opcode    <= opcode_next;
      mask      <= mask_next;
      length    <= length_next;
      key       <= key_next;
      remaining <= remaining_next;
      key_idx   <= key_idx_next;
    end
  end

endmodule

// File: design/wsfd_checker.sv
// Port-level checks for the WebSocket frame deframer and their binding.
module wsfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        result_kind,
  input logic [7:0]  payload_byte,
  input logic        mask_present,
  input logic [63:0] body_length,
  input logic [3:0]  header_size,
  input logic        last_of_frame
);
  import wsfd_pkg::*;

  // A held result beat keeps its kind, byte, length and last flag until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(payload_byte)
      && $stable(body_length) && $stable(last_of_frame) && $stable(result_kind))
    else $error("stalled result beat changed");

  // Input backpressure only arises from a held result beat.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> result_valid && result_stall)
    else $error("rx_stall without a held result");

  // A header beat is last exactly when the frame has no payload, and its byte is zero.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == KIND_HEADER |->
      (last_of_frame == (body_length == 64'd0)) && payload_byte == 8'd0)
    else $error("header beat last flag or byte wrong");

  // Header size is one of the legal header sizes.
  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (header_size == 4'd2 && !mask_present) || (header_size == 4'd4 && !mask_present) ||
      (header_size == 4'd10 && !mask_present) || (header_size == 4'd6 && mask_present) ||
      (header_size == 4'd8 && mask_present) || (header_size == 4'd14 && mask_present))
    else $error("illegal header size");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

// File: sim/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer: random frames, random gaps and stalls.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsfd_pkg::*;

  // Length field forms used when building frames.
  localparam int LEN_SHORT = 0;
  localparam int LEN_EXT16 = 1;
  localparam int LEN_EXT64 = 2;

  typedef struct {
    logic [7:0] data;
    bit         hold;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic        fin_flag;
  logic [2:0]  reserved_bits;
  logic [3:0]  frame_opcode;
  logic        mask_present;
  logic [63:0] body_length;
  logic [3:0]  header_size;
  logic        last_of_frame;

  rx_item_t byte_q[$];
  result_t  expect_q[$];
  result_t  next_beat;
  result_t  got_beat;
  result_t  want_beat;

  int errors = 0;
  int bytes_taken = 0;
  int beats_seen = 0;
  int frames_queued = 0;
  int frames_ext16 = 0;
  int frames_ext64 = 0;
  int frames_masked = 0;

  // Shadow copy of the parser state.
  phase_t      ph = PH_HDR0;
  logic [3:0]  hdr_count = 4'd0;
  logic        cur_fin = 1'b0;
  logic [2:0]  cur_rsv = 3'd0;
  logic [3:0]  cur_opcode = 4'd0;
  logic        cur_masked = 1'b0;
  logic [63:0] frame_len = 64'd0;
  logic [31:0] key_word = 32'd0;
  logic [63:0] left_count = 64'd0;
  logic [1:0]  key_pos = 2'd0;

  websocket_frame_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .fin_flag       (fin_flag),
    .reserved_bits  (reserved_bits),
    .frame_opcode   (frame_opcode),
    .mask_present   (mask_present),
    .body_length    (body_length),
    .header_size    (header_size),
    .last_of_frame  (last_of_frame)
  );

  // Builds a result beat from the held header fields.
  function automatic result_t make_beat(input logic kind, input logic [7:0] data,
                                        input logic last);
    result_t r;
    r.kind           = kind;
    r.payload_byte   = data;
    r.fin            = cur_fin;
    r.rsv            = cur_rsv;
    r.opcode         = cur_opcode;
    r.mask           = cur_masked;
    r.body_length    = frame_len;
    r.header_size    = hdr_count;
    r.last           = last;
    return r;
  endfunction

  // The header is complete: arm the payload count and emit the header beat.
  function automatic result_t close_header();
    logic last;
    last = (frame_len == 64'd0);
    left_count = frame_len;
    key_pos = 2'd0;
    ph = last ? PH_HDR0 : PH_PAYLOAD;
    return make_beat(KIND_HEADER, 8'h00, last);
  endfunction

  // The length is known: either collect a masking key or finish the header.
  function automatic bit finish_length(output result_t r);
    r = '0;
    if (cur_masked) begin
      key_word = 32'd0;
      key_pos = 2'd0;
      ph = PH_KEY;
      return 1'b0;
    end
    r = close_header();
    return 1'b1;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a beat is due.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [6:0] code;
    logic [7:0] kb;
    logic       last;
    bit         emit;
    emit = 1'b0;
    r = '0;
    case (ph)
      PH_HDR1: begin
        cur_masked = b[7];
        code = b[6:0];
        hdr_count = 4'd2;
        frame_len = 64'd0;
        if (code == LEN_CODE16) begin
          ph = PH_LEN16;
        end else if (code == LEN_CODE64) begin
          ph = PH_LEN64;
        end else begin
          frame_len = {57'd0, code};
          emit = finish_length(r);
        end
      end
      PH_LEN16, PH_LEN64: begin
        frame_len = {frame_len[55:0], b};
        hdr_count = hdr_count + 4'd1;
        if ((ph == PH_LEN16 && hdr_count == HDR_END16) ||
            (ph == PH_LEN64 && hdr_count == HDR_END64)) begin
          emit = finish_length(r);
        end
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_count = hdr_count + 4'd1;
        key_pos = key_pos + 2'd1;
        if (key_pos == 2'd0) begin
          r = close_header();
          emit = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        kb = cur_masked ? key_word[8 * (3 - key_pos) +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        left_count = left_count - 64'd1;
        last = (left_count == 64'd0);
        if (last) begin
          ph = PH_HDR0;
        end
        r = make_beat(KIND_PAYLOAD, b ^ kb, last);
        emit = 1'b1;
      end
      default: begin
        cur_fin = b[7];
        cur_rsv = b[6:4];
        cur_opcode = b[3:0];
        hdr_count = 4'd1;
        ph = PH_HDR1;
      end
    endcase
    return emit;
  endfunction

  // Queues one frame: base header, any extended length, optional key, then body bytes.
  task automatic queue_frame(input logic [7:0] b0, input bit masked, input int lkind,
                             input logic [63:0] len, input int body, input bit hold);
    logic [31:0] key;
    key = $urandom;
    byte_q.push_back('{b0, hold});
    case (lkind)
      LEN_EXT16: begin
        byte_q.push_back('{{masked, LEN_CODE16}, 1'b0});
        for (int i = 1; i >= 0; i--) byte_q.push_back('{len[8 * i +: 8], 1'b0});
        frames_ext16++;
      end
      LEN_EXT64: begin
        byte_q.push_back('{{masked, LEN_CODE64}, 1'b0});
        for (int i = 7; i >= 0; i--) byte_q.push_back('{len[8 * i +: 8], 1'b0});
        frames_ext64++;
      end
      default: begin
        byte_q.push_back('{{masked, len[6:0]}, 1'b0});
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) byte_q.push_back('{key[8 * i +: 8], 1'b0});
      frames_masked++;
    end
    for (int i = 0; i < body; i++) byte_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
    frames_queued++;
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Input driver: presents queued bytes, with random gaps and a gap-free stretch.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        if (deframe_byte(rx_byte, next_beat)) begin
          expect_q.push_back(next_beat);
        end
        bytes_taken++;
      end
      if (!rx_valid || !rx_stall) begin
        if (byte_q.size() != 0 && !(byte_q[0].hold && expect_q.size() != 0) &&
            ((bytes_taken >= 300 && bytes_taken < 500) || $urandom_range(0, 99) >= 34)) begin
          rx_valid <= 1'b1;
          rx_byte <= byte_q[0].data;
          void'(byte_q.pop_front());
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks every beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        beats_seen++;
        got_beat = '{result_kind, payload_byte, fin_flag, reserved_bits, frame_opcode,
                     mask_present, body_length, header_size, last_of_frame};
        if (expect_q.size() == 0) begin
          note_error($sformatf("unexpected beat %p", got_beat));
        end else begin
          want_beat = expect_q.pop_front();
          if (got_beat.kind !== want_beat.kind ||
              got_beat.payload_byte !== want_beat.payload_byte ||
              got_beat.fin !== want_beat.fin ||
              got_beat.rsv !== want_beat.rsv ||
              got_beat.opcode !== want_beat.opcode ||
              got_beat.mask !== want_beat.mask ||
              got_beat.body_length !== want_beat.body_length ||
              got_beat.header_size !== want_beat.header_size ||
              got_beat.last !== want_beat.last) begin
            note_error($sformatf("beat %0d expected %p actual %p",
                                 beats_seen, want_beat, got_beat));
          end
        end
      end
      result_stall <= (beats_seen >= 300 && beats_seen < 500) ? 1'b0
                      : ($urandom_range(0, 99) < 34);
    end
  end

  // Stimulus and end of run.
  initial begin
    int sel;
    int len;
    int lkind;

    // Directed frames: empty frame, all header bits set with a key,
    // empty masked frame behind a 16-bit length, empty masked frame behind a 64-bit length.
    queue_frame(8'h00, 1'b0, LEN_SHORT, 64'd0, 0, 1'b0);
    queue_frame(8'hff, 1'b1, LEN_SHORT, 64'd1, 1, 1'b0);
    queue_frame(8'hf0, 1'b1, LEN_EXT16, 64'd0, 0, 1'b0);
    queue_frame(8'h41, 1'b1, LEN_EXT64, 64'd0, 0, 1'b0);

    // Random well-formed frames with mostly short bodies.
    while (byte_q.size() < 1000) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        lkind = LEN_SHORT;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 125) : $urandom_range(0, 12);
      end else if (sel < 90) begin
        lkind = LEN_EXT16;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 20);
      end else begin
        lkind = LEN_EXT64;
        len = $urandom_range(0, 16);
      end
      queue_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), lkind, 64'(len),
                  len, (frames_queued % 40) == 20);
    end

    // Last frame announces a length with the top bit set; only part of it is sent.
    queue_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_EXT64,
                {1'b1, 31'($urandom), 32'($urandom)}, 24, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || rx_valid) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d frames (%0d with 16-bit length, %0d with 64-bit, %0d masked).",
             frames_queued, frames_ext16, frames_ext64, frames_masked);
    $display("%0d bytes sent, %0d result beats checked, %0d errors.",
             bytes_taken, beats_seen, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Timed out with %0d beats outstanding.", expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
design/wsfd_pkg.sv
design/wsfd_parser.sv
design/websocket_frame_deframer.sv
design/wsfd_checker.sv
sim/websocket_frame_deframer_tb.sv
